// ===== hw/rtl/login_lockout_throttle_macros.svh =====
// Assertion helpers for the throttle controller RTL.
`ifndef LOGIN_LOCKOUT_THROTTLE_MACROS_SVH
`define LOGIN_LOCKOUT_THROTTLE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/llt_pkg.sv =====
`default_nettype none
package llt_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY_NAME = 3'd1;
  localparam logic [2:0] ST_LOCKED     = 3'd2;
  localparam logic [2:0] ST_BAD_CRED   = 3'd3;
  localparam logic [2:0] ST_LOGGED_OUT = 3'd4;
  localparam logic [2:0] ST_NO_SESSION = 3'd5;

  // Register byte addresses.
  localparam int unsigned AddrW = 4;
  localparam logic [AddrW-1:0] ADDR_FAIL_LIMIT  = 4'h0;
  localparam logic [AddrW-1:0] ADDR_LOCKOUT_MS  = 4'h4;
  localparam logic [AddrW-1:0] ADDR_FAIL_WINDOW = 4'h8;

  // Register reset values.
  localparam logic [7:0]  RST_FAIL_LIMIT  = 8'd5;
  localparam logic [19:0] RST_LOCKOUT_MS  = 20'd30000;
  localparam logic [19:0] RST_FAIL_WINDOW = 20'd30000;

  // Field widths.
  localparam int unsigned KeyW  = 32;
  localparam int unsigned TimeW = 48;
  localparam int unsigned CntW  = 8;
  localparam int unsigned RemW  = 10;

  // Remaining-time arithmetic: ceil(ms / 1000) via reciprocal multiply.
  localparam logic [TimeW-1:0] REM_SAT_MS  = 48'd1023000;
  localparam logic [19:0]      ROUND_UP_MS = 20'd999;
  localparam logic [30:0]      RECIP_1000  = 31'd1099511628;
  localparam int unsigned      RecipShift  = 40;
  localparam logic [RemW-1:0]  REM_MAX     = 10'd1023;
  localparam logic [TimeW-1:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [CntW-1:0]  CNT_MAX     = 8'd255;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [7:0]  fail_limit;
    logic [19:0] lockout_ms;
    logic [19:0] fail_window_ms;
  } llt_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic scan;
    logic eval;
    logic prep;
    logic mul;
    logic commit;
  } llt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;
  } llt_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/llt_regs.sv =====
`default_nettype none
module llt_regs
  import llt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output llt_cfg_t              cfg_o
);

  logic [7:0]  fail_limit_q;
  logic [19:0] lockout_q;
  logic [19:0] window_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_limit_q <= RST_FAIL_LIMIT;
      lockout_q    <= RST_LOCKOUT_MS;
      window_q     <= RST_FAIL_WINDOW;
    end else if (wr_en) begin
      case (paddr)
        ADDR_FAIL_LIMIT:  fail_limit_q <= pwdata[7:0];
        ADDR_LOCKOUT_MS:  lockout_q    <= pwdata[19:0];
        ADDR_FAIL_WINDOW: window_q     <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (paddr)
      ADDR_FAIL_LIMIT:  prdata = {24'd0, fail_limit_q};
      ADDR_LOCKOUT_MS:  prdata = {12'd0, lockout_q};
      ADDR_FAIL_WINDOW: prdata = {12'd0, window_q};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o.fail_limit     = fail_limit_q;
  assign cfg_o.lockout_ms     = lockout_q;
  assign cfg_o.fail_window_ms = window_q;

endmodule
`default_nettype wire

// ===== hw/rtl/llt_ctrl.sv =====
`default_nettype none
`include "login_lockout_throttle_macros.svh"
module llt_ctrl
  import llt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire llt_stat_t stat_i,
  output logic           busy_o,
  output llt_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_PREP   = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `LLT_ASSERT_NEXT(a_accept_scans, clk_i, rst_ni, state_q == S_IDLE && start_i, state_q == S_SCAN, "accepted transaction did not start a scan")
  `LLT_ASSERT_NEXT(a_commit_idles, clk_i, rst_ni, state_q == S_COMMIT, state_q == S_IDLE && !busy_o, "controller stayed busy after commit")
  `LLT_ASSERT_NOW(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.load, cmd_o.scan, cmd_o.eval, cmd_o.prep, cmd_o.mul, cmd_o.commit}), "more than one command issued")

endmodule
`default_nettype wire

// ===== hw/rtl/llt_dp.sv =====
`default_nettype none
module llt_dp
  import llt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire llt_cmd_t         cmd_i,
  output llt_stat_t             stat_o,
  input  wire llt_cfg_t         cfg_i,
  input  wire logic             action_i,
  input  wire logic [KeyW-1:0]  user_key_i,
  input  wire logic             credential_ok_i,
  input  wire logic [TimeW-1:0] now_ms_i,
  output logic                  done_o,
  output logic [2:0]            status_o,
  output logic [RemW-1:0]       remaining_secs_o,
  output logic [31:0]           sess_num_o,
  output logic                  session_active_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(SLOTS - 1);

  // Slot table, one read and one write port.
  logic [KeyW-1:0]  mem_user  [SLOTS];
  logic [CntW-1:0]  mem_fail  [SLOTS];
  logic [TimeW-1:0] mem_touch [SLOTS];
  logic [TimeW-1:0] mem_lock  [SLOTS];
  logic [SLOTS-1:0] vld_q;

  // Captured transaction.
  logic             act_q;
  logic [KeyW-1:0]  key_q;
  logic             cred_q;
  logic [TimeW-1:0] now_q;

  // Scan pipeline.
  logic [IdxW-1:0]  cnt_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic             rd_vbit_q;
  logic [KeyW-1:0]  rd_user_q;
  logic [CntW-1:0]  rd_fail_q;
  logic [TimeW-1:0] rd_touch_q;
  logic [TimeW-1:0] rd_lock_q;
  logic [KeyW-1:0]  e_user;
  logic [CntW-1:0]  e_fail;
  logic [TimeW-1:0] e_touch;
  logic [TimeW-1:0] e_lock;

  // Scan results.
  logic             match_q;
  logic [IdxW-1:0]  match_idx_q;
  logic [CntW-1:0]  m_fail_q;
  logic [TimeW-1:0] m_touch_q;
  logic [TimeW-1:0] m_lock_q;
  logic             empty_q;
  logic [IdxW-1:0]  empty_idx_q;
  logic [TimeW-1:0] min_touch_q;
  logic [IdxW-1:0]  min_idx_q;

  // Evaluation pipeline.
  logic             lock_act;
  logic [TimeW-1:0] last_touch;
  logic             locked_q;
  logic [TimeW-1:0] rem_q;
  logic [CntW-1:0]  base_fail_q;
  logic             last_nz_q;
  logic             back_q;
  logic [TimeW-1:0] gap_q;
  logic [IdxW-1:0]  widx_q;
  logic             sat_q;
  logic [19:0]      y_q;
  logic [CntW-1:0]  count_q;
  logic [TimeW-1:0] end_q;
  logic             stale;
  logic [CntW-1:0]  c0;
  logic [TimeW:0]   end_sum;
  logic [50:0]      prod_q;
  logic [TimeW-1:0] lock_new_q;

  // Table write port.
  logic             we;
  logic [KeyW-1:0]  w_user;
  logic [CntW-1:0]  w_fail;
  logic [TimeW-1:0] w_touch;
  logic [TimeW-1:0] w_lock;

  // Session state.
  logic [31:0]      session_q;
  logic             logged_in_q;
  logic             done_q;

  // Capture the transaction and step the scan counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      key_q  <= user_key_i;
      cred_q <= credential_ok_i;
      now_q  <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.scan) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign stat_o.scan_last = (cnt_q == LAST_IDX);

  // Table memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_user[widx_q]  <= w_user;
      mem_fail[widx_q]  <= w_fail;
      mem_touch[widx_q] <= w_touch;
      mem_lock[widx_q]  <= w_lock;
    end
    if (cmd_i.scan) begin
      rd_user_q  <= mem_user[cnt_q];
      rd_fail_q  <= mem_fail[cnt_q];
      rd_touch_q <= mem_touch[cnt_q];
      rd_lock_q  <= mem_lock[cnt_q];
      rd_vbit_q  <= vld_q[cnt_q];
      rd_idx_q   <= cnt_q;
    end
  end

  // Entries never written read as an empty slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[widx_q] <= 1'b1;
    end
  end

  assign e_user  = rd_vbit_q ? rd_user_q  : '0;
  assign e_fail  = rd_vbit_q ? rd_fail_q  : '0;
  assign e_touch = rd_vbit_q ? rd_touch_q : '0;
  assign e_lock  = rd_vbit_q ? rd_lock_q  : '0;

  // Fold each returned entry into match, first empty and oldest slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      match_q <= 1'b0;
      empty_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (e_user == '0) begin
        if (!empty_q) begin
          empty_q     <= 1'b1;
          empty_idx_q <= rd_idx_q;
        end
      end else begin
        if (e_user == key_q) begin
          match_q     <= 1'b1;
          match_idx_q <= rd_idx_q;
          m_fail_q    <= e_fail;
          m_touch_q   <= e_touch;
          m_lock_q    <= e_lock;
        end
        if (rd_idx_q == '0 || e_touch < min_touch_q) begin
          min_touch_q <= e_touch;
          min_idx_q   <= rd_idx_q;
        end
      end
    end
  end

  // First evaluation step: lock check and failure streak gap.
  assign lock_act   = match_q && (m_lock_q != '0);
  assign last_touch = match_q ? m_touch_q : now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      locked_q    <= lock_act && (now_q < m_lock_q);
      rem_q       <= m_lock_q - now_q;
      base_fail_q <= (match_q && !lock_act) ? m_fail_q : '0;
      last_nz_q   <= (last_touch != '0);
      back_q      <= (now_q < last_touch);
      gap_q       <= now_q - last_touch;
      widx_q      <= match_q ? match_idx_q : (empty_q ? empty_idx_q : min_idx_q);
    end
  end

  // Second step: new fail count, lock end and rounding operand.
  assign stale   = last_nz_q && (back_q || gap_q > {28'd0, cfg_i.fail_window_ms});
  assign c0      = stale ? '0 : base_fail_q;
  assign end_sum = {1'b0, now_q} + {29'd0, cfg_i.lockout_ms};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      sat_q   <= rem_q > REM_SAT_MS;
      y_q     <= rem_q[19:0] + ROUND_UP_MS;
      count_q <= (c0 == CNT_MAX) ? c0 : c0 + 1'b1;
      end_q   <= end_sum[TimeW] ? TIME_MAX : end_sum[TimeW-1:0];
    end
  end

  // Third step: reciprocal multiply and lock decision.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q     <= {31'd0, y_q} * {20'd0, RECIP_1000};
      lock_new_q <= (count_q >= cfg_i.fail_limit) ? end_q : '0;
    end
  end

  // Table update at commit.
  always_comb begin
    we      = 1'b0;
    w_user  = '0;
    w_fail  = '0;
    w_touch = '0;
    w_lock  = '0;
    if (cmd_i.commit && !act_q && key_q != '0 && !locked_q) begin
      if (!cred_q) begin
        we      = 1'b1;
        w_user  = key_q;
        w_fail  = count_q;
        w_touch = now_q;
        w_lock  = lock_new_q;
      end else begin
        we = match_q;
      end
    end
  end

  // Result and session state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q   <= '0;
      logged_in_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (act_q) begin
          logged_in_q <= 1'b0;
        end else if (key_q != '0 && !locked_q && cred_q) begin
          session_q   <= session_q + 1'b1;
          logged_in_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      remaining_secs_o <= '0;
      if (act_q) begin
        status_o <= logged_in_q ? ST_LOGGED_OUT : ST_NO_SESSION;
      end else if (key_q == '0) begin
        status_o <= ST_EMPTY_NAME;
      end else if (locked_q) begin
        status_o         <= ST_LOCKED;
        remaining_secs_o <= sat_q ? REM_MAX : prod_q[RecipShift +: RemW];
      end else if (!cred_q) begin
        status_o <= ST_BAD_CRED;
      end else begin
        status_o <= ST_OK;
      end
    end
  end

  assign done_o           = done_q;
  assign sess_num_o       = session_q;
  assign session_active_o = logged_in_q;

endmodule
`default_nettype wire

// ===== hw/rtl/login_lockout_throttle.sv =====
// Login throttle with a per-user failure table. A transaction is accepted on a
// rising edge with start high and busy low; busy then stays high while the
// table is scanned through its single read port, one entry a cycle, followed
// by evaluation, a reciprocal multiply and the table update.
// The result is shown for exactly one cycle, marked by done_o, in the first
// cycle after busy falls; the receiver cannot stall it, so it must capture
// the result in that cycle. A new transaction may be started in that same
// cycle. sess_num_o and session_active_o also show the live session state
// between results. Registers must be written only while busy is low; the
// block itself does not enforce this.
`default_nettype none
module login_lockout_throttle
  import llt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             action_i,
  input  wire logic [KeyW-1:0]  user_key_i,
  input  wire logic             credential_ok_i,
  input  wire logic [TimeW-1:0] now_ms_i,
  output logic                  done_o,
  output logic [2:0]            status_o,
  output logic [RemW-1:0]       remaining_secs_o,
  output logic [31:0]           sess_num_o,
  output logic                  session_active_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  llt_cfg_t  cfg;
  llt_cmd_t  cmd;
  llt_stat_t stat;

  llt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  llt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  llt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_i            (cfg),
    .action_i         (action_i),
    .user_key_i       (user_key_i),
    .credential_ok_i  (credential_ok_i),
    .now_ms_i         (now_ms_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .remaining_secs_o (remaining_secs_o),
    .sess_num_o       (sess_num_o),
    .session_active_o (session_active_o)
  );

endmodule
`default_nettype wire
